>>> design/tlss_pkg.sv
// Shared types, codes and constants for the tiered load server selector.
`timescale 1ns / 1ps

package tlss_pkg;

    localparam int FIELD_W = 16;
    localparam int ADDR_W  = 32;
    localparam int UNIT_W  = 24;
    localparam int TIER_STEPS = 3;

    typedef logic [2:0] tier_t;

    localparam tier_t TIER_NONE = 3'd0;
    localparam tier_t TIER_BAD  = 3'd1;
    localparam tier_t TIER_OK   = 3'd2;
    localparam tier_t TIER_GOOD = 3'd3;
    localparam tier_t TIER_BEST = 3'd4;

    localparam logic MODE_UPDATE = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    localparam logic [6:0] PCT_FULL = 7'd100;
    localparam logic [6:0] PCT_OK   = 7'd75;
    localparam logic [6:0] PCT_GOOD = 7'd50;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD_TIER,
        ST_SCAN,
        ST_DRAIN,
        ST_PICK,
        ST_SERVE
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  address;
        logic [FIELD_W-1:0] port;
    } slot_id_t;

    typedef struct packed {
        logic [FIELD_W-1:0] load;
        logic [FIELD_W-1:0] limit;
        logic [FIELD_W-1:0] reserved;
        tier_t              tier;
    } slot_stat_t;

    typedef struct packed {
        logic upd_we;
        logic rsv_we;
    } tbl_ctl_t;

    // Percent threshold tested at each step of the tier search.
    function automatic logic [6:0] tier_pct(input logic [1:0] step);
        logic [6:0] pct;
        case (step)
            2'd0:    pct = PCT_FULL;
            2'd1:    pct = PCT_OK;
            2'd2:    pct = PCT_GOOD;
            default: pct = PCT_FULL;
        endcase
        return pct;
    endfunction

    // Tier given when load reaches the threshold of that step.
    function automatic tier_t tier_on_fail(input logic [1:0] step);
        tier_t t;
        case (step)
            2'd0:    t = TIER_BAD;
            2'd1:    t = TIER_OK;
            default: t = TIER_GOOD;
        endcase
        return t;
    endfunction

endpackage

>>> design/tlss_table.sv
// Slot table: valid flags in flops, identity and load memories with registered read.
`timescale 1ns / 1ps

module tlss_table #(
    parameter int SLOT_COUNT = 16,
    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [IDX_W-1:0]    rd_addr,
    output logic                rd_valid,
    output tlss_pkg::slot_id_t  rd_id,
    output tlss_pkg::slot_stat_t rd_stat,
    input  tlss_pkg::tbl_ctl_t  ctl,
    input  logic [IDX_W-1:0]    wr_addr,
    input  tlss_pkg::slot_id_t  wr_id,
    input  tlss_pkg::slot_stat_t wr_stat
);

    logic [SLOT_COUNT-1:0] valid_reg;
    logic                  rd_valid_reg;
    tlss_pkg::slot_id_t    id_mem [SLOT_COUNT];
    tlss_pkg::slot_stat_t  stat_mem [SLOT_COUNT];
    tlss_pkg::slot_id_t    rd_id_reg;
    tlss_pkg::slot_stat_t  rd_stat_reg;
    logic                  id_we;
    logic                  stat_we;

    // Identity is kept from the update that first makes a slot valid.
    assign id_we   = ctl.upd_we & ~valid_reg[wr_addr];
    assign stat_we = ctl.upd_we | ctl.rsv_we;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.upd_we)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (id_we)
        begin
            id_mem[wr_addr] <= wr_id;
        end
        if (stat_we)
        begin
            stat_mem[wr_addr] <= wr_stat;
        end
        rd_id_reg   <= id_mem[rd_addr];
        rd_stat_reg <= stat_mem[rd_addr];
    end

    assign rd_valid = rd_valid_reg;
    assign rd_id    = rd_id_reg;
    assign rd_stat  = rd_stat_reg;

endmodule

>>> design/tlss_unit.sv
// Shared add and compare unit: sum = a + b, lt = sum < c.
`timescale 1ns / 1ps

module tlss_unit (
    input  logic [tlss_pkg::UNIT_W-1:0] a,
    input  logic [tlss_pkg::UNIT_W-1:0] b,
    input  logic [tlss_pkg::UNIT_W-1:0] c,
    output logic [tlss_pkg::UNIT_W-1:0] sum,
    output logic                        lt
);

    assign sum = a + b;
    assign lt  = sum < c;

endmodule

>>> design/tlss_seq.sv
// Sequencer: word capture, tier steps, slot scan, pick, serve and result register.
`timescale 1ns / 1ps

module tlss_seq #(
    parameter int SLOT_COUNT = 16,
    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          mode,
    input  logic [3:0]                    slot_index,
    input  logic [31:0]                   server_address,
    input  logic [15:0]                   server_port_in,
    input  logic [15:0]                   current_load,
    input  logic [15:0]                   load_limit,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          found,
    output logic [3:0]                    served_index,
    output logic [31:0]                   served_address,
    output logic [15:0]                   served_port,
    output logic [2:0]                    served_tier,
    output logic [IDX_W-1:0]              rd_addr,
    input  logic                          rd_valid,
    input  tlss_pkg::slot_id_t            rd_id,
    input  tlss_pkg::slot_stat_t          rd_stat,
    output tlss_pkg::tbl_ctl_t            ctl,
    output logic [IDX_W-1:0]              wr_addr,
    output tlss_pkg::slot_id_t            wr_id,
    output tlss_pkg::slot_stat_t          wr_stat,
    output logic [tlss_pkg::UNIT_W-1:0]   op_a,
    output logic [tlss_pkg::UNIT_W-1:0]   op_b,
    output logic [tlss_pkg::UNIT_W-1:0]   op_c,
    input  logic [tlss_pkg::UNIT_W-1:0]   op_sum,
    input  logic                          op_lt
);

    localparam int UW = tlss_pkg::UNIT_W;
    localparam logic [1:0] CAND_OK   = 2'd0;
    localparam logic [1:0] CAND_GOOD = 2'd1;
    localparam logic [1:0] CAND_BEST = 2'd2;

    tlss_pkg::state_t state_reg, state_next;

    logic [1:0]         step_reg;
    logic [IDX_W-1:0]   scan_addr_reg;
    logic               eval_vld_reg;
    logic [IDX_W-1:0]   eval_idx_reg;
    logic [2:0]         cand_hit_reg;
    logic [IDX_W-1:0]   cand_idx_reg [3];
    logic [IDX_W-1:0]   chosen_idx_reg;
    tlss_pkg::tier_t    chosen_tier_reg;

    logic [IDX_W-1:0]   cap_idx_reg;
    logic [31:0]        cap_addr_reg;
    logic [15:0]        cap_port_reg;
    logic [15:0]        cap_load_reg;
    logic [15:0]        cap_limit_reg;

    logic               out_valid_reg;
    logic               found_reg;
    logic [3:0]         served_index_reg;
    logic [31:0]        served_address_reg;
    logic [15:0]        served_port_reg;
    tlss_pkg::tier_t    served_tier_reg;

    logic               in_acc;
    logic               in_range;
    logic               out_free;
    logic               scan_last;
    logic               tier_done;
    tlss_pkg::tier_t    tier_val;
    logic               any_hit;
    logic [IDX_W-1:0]   pick_idx;
    tlss_pkg::tier_t    pick_tier;
    logic               eval_ok;
    logic [1:0]         eval_cand;

    assign in_acc    = in_valid && (state_reg == tlss_pkg::ST_IDLE);
    assign in_range  = int'(slot_index) < SLOT_COUNT;
    assign out_free  = !out_valid_reg || !out_stall;
    assign scan_last = scan_addr_reg == IDX_W'(SLOT_COUNT - 1);
    assign any_hit   = |cand_hit_reg;

    // Tier search: a zero limit ends at once, otherwise stop at the first
    // threshold that the load reaches, or at the last step.
    assign tier_done = (cap_limit_reg == '0) || !op_lt
                       || (step_reg == 2'(tlss_pkg::TIER_STEPS - 1));

    always_comb
    begin
        if (cap_limit_reg == '0)
        begin
            tier_val = tlss_pkg::TIER_NONE;
        end
        else if (!op_lt)
        begin
            tier_val = tlss_pkg::tier_on_fail(step_reg);
        end
        else
        begin
            tier_val = tlss_pkg::TIER_BEST;
        end
    end

    always_comb
    begin
        if (cand_hit_reg[CAND_BEST])
        begin
            pick_idx  = cand_idx_reg[CAND_BEST];
            pick_tier = tlss_pkg::TIER_BEST;
        end
        else if (cand_hit_reg[CAND_GOOD])
        begin
            pick_idx  = cand_idx_reg[CAND_GOOD];
            pick_tier = tlss_pkg::TIER_GOOD;
        end
        else
        begin
            pick_idx  = cand_idx_reg[CAND_OK];
            pick_tier = tlss_pkg::TIER_OK;
        end
    end

    // A slot qualifies when valid, in a servable tier and below its limit.
    assign eval_ok = eval_vld_reg && rd_valid && op_lt
                     && (rd_stat.tier == tlss_pkg::TIER_OK
                         || rd_stat.tier == tlss_pkg::TIER_GOOD
                         || rd_stat.tier == tlss_pkg::TIER_BEST);
    assign eval_cand = 2'(rd_stat.tier - tlss_pkg::TIER_OK);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tlss_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (mode == tlss_pkg::MODE_QUERY)
                    begin
                        state_next = tlss_pkg::ST_SCAN;
                    end
                    else if (in_range)
                    begin
                        state_next = tlss_pkg::ST_UPD_TIER;
                    end
                end
            end
            tlss_pkg::ST_UPD_TIER:
            begin
                if (tier_done)
                begin
                    state_next = tlss_pkg::ST_IDLE;
                end
            end
            tlss_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = tlss_pkg::ST_DRAIN;
                end
            end
            tlss_pkg::ST_DRAIN:
            begin
                state_next = tlss_pkg::ST_PICK;
            end
            tlss_pkg::ST_PICK:
            begin
                if (any_hit)
                begin
                    state_next = tlss_pkg::ST_SERVE;
                end
                else if (out_free)
                begin
                    state_next = tlss_pkg::ST_IDLE;
                end
            end
            tlss_pkg::ST_SERVE:
            begin
                if (out_free)
                begin
                    state_next = tlss_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tlss_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        in_stall   = 1'b1;
        ctl.upd_we = 1'b0;
        ctl.rsv_we = 1'b0;
        rd_addr    = scan_addr_reg;
        wr_addr    = cap_idx_reg;
        wr_id.address = cap_addr_reg;
        wr_id.port    = cap_port_reg;
        wr_stat.load     = cap_load_reg;
        wr_stat.limit    = cap_limit_reg;
        wr_stat.reserved = '0;
        wr_stat.tier     = tier_val;
        op_a = '0;
        op_b = '0;
        op_c = '0;
        unique case (state_reg)
            tlss_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            tlss_pkg::ST_UPD_TIER:
            begin
                ctl.upd_we = tier_done;
                op_a = UW'(cap_load_reg) * UW'(tlss_pkg::PCT_FULL);
                op_c = UW'(cap_limit_reg) * UW'(tlss_pkg::tier_pct(step_reg));
            end
            tlss_pkg::ST_SCAN, tlss_pkg::ST_DRAIN:
            begin
                op_a = UW'(rd_stat.load);
                op_b = UW'(rd_stat.reserved);
                op_c = UW'(rd_stat.limit);
            end
            tlss_pkg::ST_PICK:
            begin
                rd_addr = pick_idx;
            end
            tlss_pkg::ST_SERVE:
            begin
                rd_addr    = chosen_idx_reg;
                wr_addr    = chosen_idx_reg;
                ctl.rsv_we = out_free;
                op_a = UW'(rd_stat.reserved);
                op_b = UW'(1);
                wr_stat.load     = rd_stat.load;
                wr_stat.limit    = rd_stat.limit;
                wr_stat.reserved = op_sum[tlss_pkg::FIELD_W-1:0];
                wr_stat.tier     = rd_stat.tier;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tlss_pkg::ST_IDLE;
            step_reg      <= '0;
            scan_addr_reg <= '0;
            eval_vld_reg  <= 1'b0;
            cand_hit_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            eval_vld_reg <= state_reg == tlss_pkg::ST_SCAN;
            if (in_acc)
            begin
                step_reg      <= '0;
                scan_addr_reg <= '0;
                cand_hit_reg  <= '0;
            end
            else
            begin
                if (state_reg == tlss_pkg::ST_UPD_TIER && !tier_done)
                begin
                    step_reg <= step_reg + 2'd1;
                end
                if (state_reg == tlss_pkg::ST_SCAN)
                begin
                    scan_addr_reg <= scan_addr_reg + IDX_W'(1);
                end
                if (eval_ok && !cand_hit_reg[eval_cand])
                begin
                    cand_hit_reg[eval_cand] <= 1'b1;
                end
            end
            if ((state_reg == tlss_pkg::ST_PICK && !any_hit && out_free)
                || (state_reg == tlss_pkg::ST_SERVE && out_free))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cap_idx_reg   <= IDX_W'(slot_index);
            cap_addr_reg  <= server_address;
            cap_port_reg  <= server_port_in;
            cap_load_reg  <= current_load;
            cap_limit_reg <= load_limit;
        end
        if (!in_acc && eval_ok && !cand_hit_reg[eval_cand])
        begin
            cand_idx_reg[eval_cand] <= eval_idx_reg;
        end
        if (state_reg == tlss_pkg::ST_PICK)
        begin
            chosen_idx_reg  <= pick_idx;
            chosen_tier_reg <= pick_tier;
        end
        if (state_reg == tlss_pkg::ST_PICK && !any_hit && out_free)
        begin
            found_reg          <= 1'b0;
            served_index_reg   <= '0;
            served_address_reg <= '0;
            served_port_reg    <= '0;
            served_tier_reg    <= tlss_pkg::TIER_NONE;
        end
        else if (state_reg == tlss_pkg::ST_SERVE && out_free)
        begin
            found_reg          <= 1'b1;
            served_index_reg   <= 4'(chosen_idx_reg);
            served_address_reg <= rd_id.address;
            served_port_reg    <= rd_id.port;
            served_tier_reg    <= chosen_tier_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        eval_idx_reg <= scan_addr_reg;
    end

    assign out_valid      = out_valid_reg;
    assign found          = found_reg;
    assign served_index   = served_index_reg;
    assign served_address = served_address_reg;
    assign served_port    = served_port_reg;
    assign served_tier    = served_tier_reg;

endmodule

>>> design/tiered_load_server_selector.sv
// Top level of the tiered load server selector: table, shared unit and sequencer.
`timescale 1ns / 1ps

// Channel  | Handshake           | Word
// ---------+---------------------+-----------------------------------------------
// in       | in_valid / in_stall | mode, slot_index, server_address,
//          |                     | server_port_in, current_load, load_limit
// out      | out_valid/out_stall | found, served_index, served_address,
//          |                     | served_port, served_tier
//
// Flow: one word at a time. An update tests the tier thresholds one after
//   another on the shared add/compare unit. A query scans every slot,
//   reading one slot a cycle through the table's single read port, then
//   passes a drain and a pick step before the result register loads, and a
//   hit adds a serve step.
// Reset: clears the valid flags and all control state; no clearing pass.
// Stalls: a result waits in the output register while out_stall is high; the
//   next word is still accepted, and a later query holds in its final step
//   until the register frees.

module tiered_load_server_selector #(
    parameter int SLOT_COUNT = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [3:0]  slot_index,
    input  logic [31:0] server_address,
    input  logic [15:0] server_port_in,
    input  logic [15:0] current_load,
    input  logic [15:0] load_limit,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        found,
    output logic [3:0]  served_index,
    output logic [31:0] served_address,
    output logic [15:0] served_port,
    output logic [2:0]  served_tier
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // Table read port: one slot per cycle, data in the cycle after the address.
    logic [IDX_W-1:0]        rd_addr;
    logic                    rd_valid;
    tlss_pkg::slot_id_t      rd_id;
    tlss_pkg::slot_stat_t    rd_stat;

    // Table write port: update writes and reservation bumps.
    tlss_pkg::tbl_ctl_t      ctl;
    logic [IDX_W-1:0]        wr_addr;
    tlss_pkg::slot_id_t      wr_id;
    tlss_pkg::slot_stat_t    wr_stat;

    // Shared unit operands, steered by the sequencer state.
    logic [tlss_pkg::UNIT_W-1:0] op_a;
    logic [tlss_pkg::UNIT_W-1:0] op_b;
    logic [tlss_pkg::UNIT_W-1:0] op_c;
    logic [tlss_pkg::UNIT_W-1:0] op_sum;
    logic                        op_lt;

    tlss_table #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_addr  (rd_addr),
        .rd_valid (rd_valid),
        .rd_id    (rd_id),
        .rd_stat  (rd_stat),
        .ctl      (ctl),
        .wr_addr  (wr_addr),
        .wr_id    (wr_id),
        .wr_stat  (wr_stat)
    );

    // One adder and one compare serve every step: tier thresholds on update,
    // load + reservations < limit during the scan, reservation bump on serve.
    tlss_unit u_unit (
        .a   (op_a),
        .b   (op_b),
        .c   (op_c),
        .sum (op_sum),
        .lt  (op_lt)
    );

    tlss_seq #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .slot_index     (slot_index),
        .server_address (server_address),
        .server_port_in (server_port_in),
        .current_load   (current_load),
        .load_limit     (load_limit),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .found          (found),
        .served_index   (served_index),
        .served_address (served_address),
        .served_port    (served_port),
        .served_tier    (served_tier),
        .rd_addr        (rd_addr),
        .rd_valid       (rd_valid),
        .rd_id          (rd_id),
        .rd_stat        (rd_stat),
        .ctl            (ctl),
        .wr_addr        (wr_addr),
        .wr_id          (wr_id),
        .wr_stat        (wr_stat),
        .op_a           (op_a),
        .op_b           (op_b),
        .op_c           (op_c),
        .op_sum         (op_sum),
        .op_lt          (op_lt)
    );

    logic in_acc;
    assign in_acc = in_valid && !in_stall;

    // An update never produces a result word.
    a_update_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && mode == tlss_pkg::MODE_UPDATE |=> !$rose(out_valid))
        else $error("update produced a result word");

    // A query keeps the block busy while it scans.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && mode == tlss_pkg::MODE_QUERY |=> in_stall)
        else $error("block ready right after a query");

    // A served slot always comes from a servable tier.
    a_found_tier: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> (served_tier == tlss_pkg::TIER_OK
                                || served_tier == tlss_pkg::TIER_GOOD
                                || served_tier == tlss_pkg::TIER_BEST))
        else $error("served slot has no servable tier");

    // A miss carries a zero index and no tier.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> served_index == '0
                                && served_tier == tlss_pkg::TIER_NONE)
        else $error("miss word not cleared");

endmodule

>>> bench/tiered_load_server_selector_tb.sv
// Self-checking bench for the tiered load server selector: directed and random words.
`timescale 1ns / 1ps

module tiered_load_server_selector_tb;

    localparam int SLOTS          = 16;
    // Idle edges in a row before the run is called hung. The slowest honest
    // stretch is a long input gap, a full query scan and a long output stall,
    // so this limit leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 2000;
    // An update makes no result word, so give the last one time to settle.
    localparam int TAIL_CYCLES    = 2 * SLOTS + 8;

    // One input word as the bench builds it.
    typedef struct packed {
        logic        mode;
        logic [3:0]  idx;
        logic [31:0] addr;
        logic [15:0] port;
        logic [15:0] load;
        logic [15:0] limit;
    } server_req_t;

    // One result word as the predictor expects it.
    typedef struct packed {
        logic              found;
        logic [3:0]        idx;
        logic [31:0]       addr;
        logic [15:0]       port;
        tlss_pkg::tier_t   tier;
    } server_pick_t;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        in_valid       = 1'b0;
    logic        mode           = tlss_pkg::MODE_UPDATE;
    logic [3:0]  slot_index     = 4'd0;
    logic [31:0] server_address = 32'd0;
    logic [15:0] server_port_in = 16'd0;
    logic [15:0] current_load   = 16'd0;
    logic [15:0] load_limit     = 16'd0;
    logic        out_stall      = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic        found;
    logic [3:0]  served_index;
    logic [31:0] served_address;
    logic [15:0] served_port;
    logic [2:0]  served_tier;

    // Shadow copy of the slot table, advanced once per accepted word.
    logic            tbl_valid    [SLOTS];
    logic [31:0]     tbl_addr     [SLOTS];
    logic [15:0]     tbl_port     [SLOTS];
    logic [15:0]     tbl_load     [SLOTS];
    logic [15:0]     tbl_limit    [SLOTS];
    logic [15:0]     tbl_reserved [SLOTS];
    tlss_pkg::tier_t tbl_tier     [SLOTS];

    // Picks predicted for accepted queries, oldest first.
    server_pick_t pending_picks [$];
    server_pick_t head_pick;

    int  errors        = 0;
    int  updates_sent  = 0;
    int  queries_sent  = 0;
    int  served_hits   = 0;
    int  served_misses = 0;
    int  idle_cycles   = 0;
    int  stall_run     = 0;
    // When set, neither side inserts gaps or stalls.
    bit  steady        = 1'b0;

    tiered_load_server_selector #(
        .SLOT_COUNT(SLOTS)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .slot_index     (slot_index),
        .server_address (server_address),
        .server_port_in (server_port_in),
        .current_load   (current_load),
        .load_limit     (load_limit),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .found          (found),
        .served_index   (served_index),
        .served_address (served_address),
        .served_port    (served_port),
        .served_tier    (served_tier)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Tier from load as a percentage of the limit; a zero limit has no tier.
    function automatic tlss_pkg::tier_t tier_for_load(input logic [15:0] load,
                                                      input logic [15:0] limit);
        logic [31:0] pct;
        if (limit == 16'd0)
            return tlss_pkg::TIER_NONE;
        pct = (32'(load) * 32'd100) / 32'(limit);
        if (pct >= 32'(tlss_pkg::PCT_FULL))
            return tlss_pkg::TIER_BAD;
        if (pct >= 32'(tlss_pkg::PCT_OK))
            return tlss_pkg::TIER_OK;
        if (pct >= 32'(tlss_pkg::PCT_GOOD))
            return tlss_pkg::TIER_GOOD;
        return tlss_pkg::TIER_BEST;
    endfunction

    // Advance the shadow table by one accepted word; queue a pick for a query.
    function automatic void apply_word(input server_req_t w);
        server_pick_t    pick;
        logic [16:0]     used;
        tlss_pkg::tier_t want_tier;
        bit              hit;
        if (w.mode == tlss_pkg::MODE_UPDATE)
        begin
            // Address and port stick from the update that first made the slot valid.
            if (!tbl_valid[w.idx])
            begin
                tbl_addr[w.idx]  = w.addr;
                tbl_port[w.idx]  = w.port;
                tbl_valid[w.idx] = 1'b1;
            end
            tbl_load[w.idx]     = w.load;
            tbl_limit[w.idx]    = w.limit;
            tbl_reserved[w.idx] = 16'd0;
            tbl_tier[w.idx]     = tier_for_load(w.load, w.limit);
            updates_sent++;
        end
        else
        begin
            pick = '0;
            hit  = 1'b0;
            // Walk tiers best, good, ok; first slot with headroom wins.
            for (int k = 0; k < tlss_pkg::TIER_STEPS && !hit; k++)
            begin
                want_tier = tlss_pkg::tier_t'(tlss_pkg::TIER_BEST - 3'(k));
                for (int i = 0; i < SLOTS && !hit; i++)
                begin
                    if (tbl_valid[i] && tbl_tier[i] == want_tier)
                    begin
                        used = {1'b0, tbl_load[i]} + {1'b0, tbl_reserved[i]};
                        if (used < {1'b0, tbl_limit[i]})
                        begin
                            tbl_reserved[i] = tbl_reserved[i] + 16'd1;
                            pick.found = 1'b1;
                            pick.idx   = 4'(i);
                            pick.addr  = tbl_addr[i];
                            pick.port  = tbl_port[i];
                            pick.tier  = want_tier;
                            hit        = 1'b1;
                        end
                    end
                end
            end
            pending_picks.push_back(pick);
            queries_sent++;
        end
    endfunction

    function automatic server_req_t pack_req(input logic m, input logic [3:0] idx,
                                             input logic [31:0] addr, input logic [15:0] port,
                                             input logic [15:0] load, input logic [15:0] limit);
        server_req_t w;
        w.mode  = m;
        w.idx   = idx;
        w.addr  = addr;
        w.port  = port;
        w.load  = load;
        w.limit = limit;
        return w;
    endfunction

    // A query carries random junk in the fields it does not use.
    function automatic server_req_t query_word();
        return pack_req(tlss_pkg::MODE_QUERY, 4'($urandom_range(0, 15)), $urandom,
                        16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                        16'($urandom_range(0, 65535)));
    endfunction

    // Mostly small limits so reservations run out and queries fall through tiers.
    function automatic server_req_t update_word();
        logic [15:0] load;
        logic [15:0] limit;
        case ($urandom_range(0, 9))
            0:
            begin
                load  = 16'($urandom_range(0, 65535));
                limit = 16'($urandom_range(0, 65535));
            end
            1:
            begin
                load  = 16'($urandom_range(0, 65535));
                limit = 16'd0;
            end
            default:
            begin
                limit = 16'($urandom_range(1, 12));
                load  = 16'($urandom_range(0, limit + 2));
            end
        endcase
        return pack_req(tlss_pkg::MODE_UPDATE, 4'($urandom_range(0, 15)), $urandom,
                        16'($urandom_range(0, 65535)), load, limit);
    endfunction

    // Present one word after a random gap and hold it until it is taken.
    // Valid is lowered only when a gap follows, so a back-to-back word never
    // sees a low and a high scheduled in the same step.
    task automatic send_word(input server_req_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        mode           <= w.mode;
        slot_index     <= w.idx;
        server_address <= w.addr;
        server_port_in <= w.port;
        current_load   <= w.load;
        load_limit     <= w.limit;
        do
            @(posedge clk);
        while (in_stall);
        apply_word(w);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    // A query before any update must come back empty.
    task automatic test_empty_table();
        steady = 1'b0;
        send_word(query_word());
    endtask

    // Exhaust reservations on a best slot, fall back to a good one, then run
    // dry; finally rewrite the best slot and confirm the address is kept.
    task automatic test_reservations();
        steady = 1'b0;
        send_word(pack_req(tlss_pkg::MODE_UPDATE, 4'd5, 32'h0a00_0005, 16'd8005,
                           16'd0, 16'd2));
        send_word(pack_req(tlss_pkg::MODE_UPDATE, 4'd9, 32'h0a00_0009, 16'd8009,
                           16'd3, 16'd5));
        repeat (5) send_word(query_word());
        send_word(pack_req(tlss_pkg::MODE_UPDATE, 4'd5, 32'hdead_beef, 16'd1,
                           16'd0, 16'd1));
        send_word(query_word());
    endtask

    // Loads right on and beside each tier boundary, plus the field extremes.
    task automatic test_tier_edges();
        logic upd;
        upd = tlss_pkg::MODE_UPDATE;
        steady = 1'b1;
        send_word(pack_req(upd, 4'd0,  32'h0000_0000, 16'h0000, 16'd0,     16'd0));
        send_word(pack_req(upd, 4'd1,  32'h0000_0001, 16'd1,    16'd100,   16'd100));
        send_word(pack_req(upd, 4'd2,  32'h0000_0002, 16'd2,    16'd99,    16'd100));
        send_word(pack_req(upd, 4'd3,  32'h0000_0003, 16'd3,    16'd75,    16'd100));
        send_word(pack_req(upd, 4'd4,  32'h0000_0004, 16'd4,    16'd74,    16'd100));
        send_word(pack_req(upd, 4'd6,  32'h0000_0006, 16'd6,    16'd50,    16'd100));
        send_word(pack_req(upd, 4'd7,  32'h0000_0007, 16'd7,    16'd49,    16'd100));
        send_word(pack_req(upd, 4'd8,  32'h0000_0008, 16'd8,    16'hffff,  16'hffff));
        send_word(pack_req(upd, 4'd10, 32'h0000_000a, 16'd10,   16'hffff,  16'd1));
        send_word(pack_req(upd, 4'd15, 32'hffff_ffff, 16'hffff, 16'd0,     16'hffff));
        steady = 1'b0;
        repeat (3) send_word(query_word());
    endtask

    // Random mix of updates and queries with the given share of queries.
    task automatic test_random_traffic(input int count, input int query_pct, input bit quiet);
        steady = quiet;
        repeat (count)
        begin
            if ($urandom_range(0, 99) < query_pct)
                send_word(query_word());
            else
                send_word(update_word());
        end
    endtask

    // Output side: hold stall for random runs, lowering it again between runs.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (stall_run > 0)
        begin
            stall_run  = stall_run - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            stall_run  = pick_gap();
            out_stall <= 1'b0;
        end
    end

    // Compare every accepted result word with the oldest predicted pick.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_picks.size() == 0)
            begin
                $error("result word arrived with no query outstanding");
                errors++;
            end
            else
            begin
                head_pick = pending_picks.pop_front();
                check_field("found",          32'(head_pick.found), 32'(found));
                check_field("served_index",   32'(head_pick.idx),   32'(served_index));
                check_field("served_address", head_pick.addr,       served_address);
                check_field("served_port",    32'(head_pick.port),  32'(served_port));
                check_field("served_tier",    32'(head_pick.tier),  32'(served_tier));
                if (head_pick.found)
                    served_hits++;
                else
                    served_misses++;
            end
        end
    end

    // Drop the run if neither channel moves a word for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no word moved in %0d cycles", WATCHDOG_LIMIT);
            $display("tiered_load_server_selector_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
            tbl_valid[i] = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_reservations();
        test_tier_edges();
        test_random_traffic(200, 50, 1'b1);
        test_random_traffic(400, 50, 1'b0);
        test_random_traffic(250, 70, 1'b0);
        test_random_traffic(150, 25, 1'b0);

        in_valid <= 1'b0;
        steady    = 1'b0;
        while (pending_picks.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d updates and %0d queries over all tiers and stall patterns",
                 updates_sent, queries_sent);
        $display("%0d queries served a slot, %0d found none", served_hits, served_misses);
        if (errors == 0)
            $display("tiered_load_server_selector_tb: done, clean");
        else
            $display("tiered_load_server_selector_tb: done, errors");
        $finish;
    end

endmodule

>>> filelist.f
design/tlss_pkg.sv
design/tlss_table.sv
design/tlss_unit.sv
design/tlss_seq.sv
design/tiered_load_server_selector.sv
bench/tiered_load_server_selector_tb.sv
